[hdl/hrnp_pkg.sv]
// hrnp_pkg: types and constants for the hash resize next-prime block
// used by hash_resize_next_prime_top; no dependencies
package hrnp_pkg;

    // field widths of the request and result channels
    localparam int COUNT_W  = 31;
    localparam int SIZE_W   = 32;
    localparam int STATUS_W = 2;

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_KEPT     = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_GROWN    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_UNUSED   = 2'd3;

    // first trial divisor after the even test, and its square
    localparam int FIRST_DIV    = 3;
    localparam int FIRST_DIV_SQ = 9;
    // prime reported when the doubled count is 0 or 1
    localparam int SMALLEST_PRIME = 2;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_NEXT,
        ST_TEST,
        ST_SQ,
        ST_DIV,
        ST_REM,
        ST_FINISH
    } state_t;

endpackage

[hdl/hash_resize_next_prime_top.sv]
// hash_resize_next_prime_top: load check and next-prime search by trial division
// depends on hrnp_pkg; remainders are formed by a bit-serial restoring divider
//
// Usage:
//   Request channel s_valid/s_ready carries s_entry_count and s_table_size.
//   Result channel m_valid/m_ready carries m_bucket_count and m_status.
//   If 4*count > 3*size the block searches the smallest prime above
//   2*count (mod 2^min(WIDTH, 32)) up to min(2^WIDTH-1, 2^32-1); status 1 reports the
//   prime when count > size, status 2 reports count when no prime exists,
//   status 0 returns size otherwise.
// Sequencing:
//   One request at a time. A kept size goes straight to the finish state,
//   and the next request is taken once the sequencer is back in idle.
//   Each candidate is checked for evenness, then runs the divider once per
//   trial divisor, and a prime candidate ends on a closing square test;
//   CW = min(WIDTH, 32) is the width the divider shifts through one bit
//   per cycle; divisors run 3, 5, 7, 11, 13, ... while d*d <= candidate.
//   The divider loop dominates the search time for large primes.
// Reset and stall:
//   aresetn (synchronous, active low) idles the sequencer and drops m_valid.
//   A finished result waits in the output register until taken; the next
//   request is accepted meanwhile and its result waits in the finish state.
module hash_resize_next_prime_top #(
    parameter int WIDTH = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [hrnp_pkg::COUNT_W-1:0]  s_entry_count,
    input  logic [hrnp_pkg::SIZE_W-1:0]   s_table_size,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [hrnp_pkg::SIZE_W-1:0]   m_bucket_count,
    output logic [hrnp_pkg::STATUS_W-1:0] m_status
);

    // candidate width, divisor width and square width
    localparam int CW   = (WIDTH < 32) ? WIDTH : 32;
    localparam int DW   = (CW + 1) / 2 + 2;
    localparam int SQW  = 2 * DW;
    localparam int CNTW = $clog2(CW);
    localparam logic [CW-1:0] LIMIT = {CW{1'b1}};

    hrnp_pkg::state_t state_reg, state_next;

    logic [hrnp_pkg::COUNT_W-1:0]  count_reg, count_next;
    logic [hrnp_pkg::SIZE_W-1:0]   size_reg, size_next;
    logic                          hit_reg, hit_next;
    logic                          over_reg, over_next;
    logic                          found_reg, found_next;
    logic [CW-1:0]                 cand_reg, cand_next;
    logic [DW-1:0]                 d_reg, d_next;
    logic [SQW-1:0]                sq_reg, sq_next;
    logic                          step4_reg, step4_next;
    logic [DW-1:0]                 rem_reg, rem_next;
    logic [CW-1:0]                 shift_reg, shift_next;
    logic [CNTW-1:0]               cnt_reg, cnt_next;
    logic                          m_valid_reg, m_valid_next;
    logic [hrnp_pkg::SIZE_W-1:0]   m_bucket_count_reg, m_bucket_count_next;
    logic [hrnp_pkg::STATUS_W-1:0] m_status_reg, m_status_next;

    // request-side load test and overfull test
    logic                 accept;
    logic [33:0]          four_count;
    logic [33:0]          three_size;
    logic                 load_hit;
    logic                 overfull;
    logic [CW-1:0]        doubled;
    logic [DW:0]          rem_shifted;
    logic                 rem_ge;
    logic                 out_free;

    assign accept     = s_valid && s_ready;
    assign four_count = {1'b0, s_entry_count, 2'b00};
    assign three_size = {2'b00, s_table_size} + {1'b0, s_table_size, 1'b0};
    assign load_hit   = four_count > three_size;
    assign overfull   = {1'b0, s_entry_count} > s_table_size;
    assign doubled    = CW'({s_entry_count, 1'b0});

    // one restoring-division step
    assign rem_shifted = {rem_reg, shift_reg[CW-1]};
    assign rem_ge      = rem_shifted >= {1'b0, d_reg};
    assign out_free    = !m_valid_reg || m_ready;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            hrnp_pkg::ST_IDLE: begin
                if (accept) begin
                    if (load_hit && (doubled > CW'(1))) begin
                        state_next = hrnp_pkg::ST_NEXT;
                    end else begin
                        state_next = hrnp_pkg::ST_FINISH;
                    end
                end
            end
            hrnp_pkg::ST_NEXT: begin
                if (cand_reg == LIMIT) begin
                    state_next = hrnp_pkg::ST_FINISH;
                end else begin
                    state_next = hrnp_pkg::ST_TEST;
                end
            end
            hrnp_pkg::ST_TEST: begin
                if (!cand_reg[0]) begin
                    state_next = hrnp_pkg::ST_NEXT;
                end else begin
                    state_next = hrnp_pkg::ST_SQ;
                end
            end
            hrnp_pkg::ST_SQ: begin
                if (sq_reg > SQW'(cand_reg)) begin
                    state_next = hrnp_pkg::ST_FINISH;
                end else begin
                    state_next = hrnp_pkg::ST_DIV;
                end
            end
            hrnp_pkg::ST_DIV: begin
                if (cnt_reg == '0) begin
                    state_next = hrnp_pkg::ST_REM;
                end
            end
            hrnp_pkg::ST_REM: begin
                if (rem_reg == '0) begin
                    state_next = hrnp_pkg::ST_NEXT;
                end else begin
                    state_next = hrnp_pkg::ST_SQ;
                end
            end
            hrnp_pkg::ST_FINISH: begin
                if (out_free) begin
                    state_next = hrnp_pkg::ST_IDLE;
                end
            end
            default: state_next = hrnp_pkg::ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        count_next          = count_reg;
        size_next           = size_reg;
        hit_next            = hit_reg;
        over_next           = over_reg;
        found_next          = found_reg;
        cand_next           = cand_reg;
        d_next              = d_reg;
        sq_next             = sq_reg;
        step4_next          = step4_reg;
        rem_next            = rem_reg;
        shift_next          = shift_reg;
        cnt_next            = cnt_reg;
        m_valid_next        = m_valid_reg && !m_ready;
        m_bucket_count_next = m_bucket_count_reg;
        m_status_next       = m_status_reg;
        s_ready             = (state_reg == hrnp_pkg::ST_IDLE);

        unique case (state_reg)
            hrnp_pkg::ST_IDLE: begin
                if (accept) begin
                    count_next = s_entry_count;
                    size_next  = s_table_size;
                    hit_next   = load_hit;
                    over_next  = overfull;
                    found_next = 1'b1;
                    if (doubled > CW'(1)) begin
                        cand_next = doubled;
                    end else begin
                        cand_next = CW'(hrnp_pkg::SMALLEST_PRIME);
                    end
                end
            end
            hrnp_pkg::ST_NEXT: begin
                // search ceiling reached without a prime
                if (cand_reg == LIMIT) begin
                    found_next = 1'b0;
                end else begin
                    cand_next = cand_reg + CW'(1);
                end
            end
            hrnp_pkg::ST_TEST: begin
                d_next     = DW'(hrnp_pkg::FIRST_DIV);
                sq_next    = SQW'(hrnp_pkg::FIRST_DIV_SQ);
                step4_next = 1'b0;
            end
            hrnp_pkg::ST_SQ: begin
                shift_next = cand_reg;
                rem_next   = '0;
                cnt_next   = CNTW'(CW - 1);
            end
            hrnp_pkg::ST_DIV: begin
                if (rem_ge) begin
                    rem_next = DW'(rem_shifted - {1'b0, d_reg});
                end else begin
                    rem_next = DW'(rem_shifted);
                end
                shift_next = {shift_reg[CW-2:0], 1'b0};
                cnt_next   = cnt_reg - CNTW'(1);
            end
            hrnp_pkg::ST_REM: begin
                // step through 3, 5, 7, 11, 13, ... keeping d*d alongside
                if (step4_reg) begin
                    d_next  = d_reg + DW'(4);
                    sq_next = sq_reg + (SQW'(d_reg) << 3) + SQW'(16);
                end else begin
                    d_next  = d_reg + DW'(2);
                    sq_next = sq_reg + (SQW'(d_reg) << 2) + SQW'(4);
                end
                step4_next = (d_reg == DW'(hrnp_pkg::FIRST_DIV)) ? 1'b0 : !step4_reg;
            end
            hrnp_pkg::ST_FINISH: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    if (!hit_reg) begin
                        m_bucket_count_next = size_reg;
                        m_status_next       = hrnp_pkg::STATUS_KEPT;
                    end else if (!found_reg) begin
                        m_bucket_count_next = hrnp_pkg::SIZE_W'(count_reg);
                        m_status_next       = hrnp_pkg::STATUS_OVERFLOW;
                    end else if (over_reg) begin
                        m_bucket_count_next = hrnp_pkg::SIZE_W'(cand_reg);
                        m_status_next       = hrnp_pkg::STATUS_GROWN;
                    end else begin
                        m_bucket_count_next = size_reg;
                        m_status_next       = hrnp_pkg::STATUS_KEPT;
                    end
                end
            end
            default: begin
                m_valid_next = 1'b0;
            end
        endcase
    end

    assign m_valid        = m_valid_reg;
    assign m_bucket_count = m_bucket_count_reg;
    assign m_status       = m_status_reg;

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= hrnp_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        count_reg          <= count_next;
        size_reg           <= size_next;
        hit_reg            <= hit_next;
        over_reg           <= over_next;
        found_reg          <= found_next;
        cand_reg           <= cand_next;
        d_reg              <= d_next;
        sq_reg             <= sq_next;
        step4_reg          <= step4_next;
        rem_reg            <= rem_next;
        shift_reg          <= shift_next;
        cnt_reg            <= cnt_next;
        m_bucket_count_reg <= m_bucket_count_next;
        m_status_reg       <= m_status_next;
    end

`ifndef SYNTHESIS
    // the reserved status code never leaves the block
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status != hrnp_pkg::STATUS_UNUSED))
        else $error("reserved status code on result channel");

    // a grown size is odd or two
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status == hrnp_pkg::STATUS_GROWN))
            |-> (m_bucket_count[0] || (m_bucket_count == 32'd2)))
        else $error("grown size is even");

    // the partial remainder stays below the divisor
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == hrnp_pkg::ST_DIV) |-> (rem_reg < d_reg))
        else $error("partial remainder not below divisor");

    // one request in flight: no accept right after an accept
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_ready)
        else $error("request accepted while busy");
`endif

endmodule

[tb/sv/hash_resize_next_prime_top_tb.sv]
// hash_resize_next_prime_top_tb: self-checking bench for the resize advisor, predicts
// load test, next-prime search and overflow per request and checks every result
// depends on hrnp_pkg and hash_resize_next_prime_top
`timescale 1ns / 1ps

module hash_resize_next_prime_top_tb;

    localparam int DUT_WIDTH    = 32;
    localparam int RANDOM_ITEMS = 76;
    localparam int HOLD_AFTER   = 30;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 50;
    localparam logic [hrnp_pkg::COUNT_W-1:0] COUNT_MAX     = {hrnp_pkg::COUNT_W{1'b1}};
    localparam logic [hrnp_pkg::SIZE_W-1:0]  SIZE_ALL_ONES = {hrnp_pkg::SIZE_W{1'b1}};

    typedef struct packed {
        logic [hrnp_pkg::COUNT_W-1:0] count;
        logic [hrnp_pkg::SIZE_W-1:0]  size;
    } resize_req_t;

    typedef struct packed {
        logic [hrnp_pkg::SIZE_W-1:0]   bucket_count;
        logic [hrnp_pkg::STATUS_W-1:0] status;
    } resize_result_t;

    typedef enum logic [1:0] {
        RX_FULL,
        RX_PATTERN,
        RX_RANDOM
    } rx_mode_t;

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          s_valid = 1'b0;
    logic                          s_ready;
    logic [hrnp_pkg::COUNT_W-1:0]  s_entry_count = '0;
    logic [hrnp_pkg::SIZE_W-1:0]   s_table_size = '0;
    logic                          m_valid;
    logic                          m_ready = 1'b0;
    logic [hrnp_pkg::SIZE_W-1:0]   m_bucket_count;
    logic [hrnp_pkg::STATUS_W-1:0] m_status;

    resize_req_t    resize_requests[$];
    resize_result_t expected_resizes[$];
    int             request_total = 0;
    int             results_checked = 0;
    int             error_count = 0;

    hash_resize_next_prime_top #(
        .WIDTH(DUT_WIDTH)
    ) DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_entry_count (s_entry_count),
        .s_table_size  (s_table_size),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_bucket_count(m_bucket_count),
        .m_status      (m_status)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // trial division by 2, 3 and 6k-1 / 6k+1 while d*d <= n
    function automatic bit trial_prime(logic [63:0] n);
        logic [63:0] d;
        if (n <= 1)
            return 1'b0;
        if (n == 2 || n == 3)
            return 1'b1;
        if (n % 2 == 0 || n % 3 == 0)
            return 1'b0;
        for (d = 5; d * d <= n; d += 6) begin
            if (n % d == 0 || n % (d + 2) == 0)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // load test, then smallest prime above the doubled count up to the ceiling
    function automatic resize_result_t predict_resize(logic [hrnp_pkg::COUNT_W-1:0] count,
                                                      logic [hrnp_pkg::SIZE_W-1:0] size);
        logic [63:0]    count64;
        logic [63:0]    size64;
        logic [63:0]    mask;
        logic [63:0]    ceiling;
        logic [63:0]    cand;
        logic [63:0]    prime;
        bit             found;
        resize_result_t res;
        count64 = count;
        size64  = size;
        mask    = (DUT_WIDTH >= 64) ? {64{1'b1}} : ((64'd1 << DUT_WIDTH) - 1);
        ceiling = (mask < 64'hFFFF_FFFF) ? mask : 64'hFFFF_FFFF;
        res.bucket_count = size;
        res.status       = hrnp_pkg::STATUS_KEPT;
        if (count64 * 4 > size64 * 3) begin
            cand  = (count64 * 2) & mask;
            found = 1'b0;
            prime = 0;
            if (cand <= 1) begin
                found = 1'b1;
                prime = 2;
            end else begin
                while (!found && cand < ceiling) begin
                    cand++;
                    if (trial_prime(cand)) begin
                        found = 1'b1;
                        prime = cand;
                    end
                end
            end
            if (!found) begin
                res.bucket_count = count64[hrnp_pkg::SIZE_W-1:0];
                res.status       = hrnp_pkg::STATUS_OVERFLOW;
            end else if (count64 > size64) begin
                res.bucket_count = prime[hrnp_pkg::SIZE_W-1:0];
                res.status       = hrnp_pkg::STATUS_GROWN;
            end
        end
        return res;
    endfunction

    function automatic void add_request(logic [hrnp_pkg::COUNT_W-1:0] count,
                                        logic [hrnp_pkg::SIZE_W-1:0] size);
        resize_req_t req;
        req.count = count;
        req.size  = size;
        resize_requests.push_back(req);
        request_total++;
    endfunction

    // request driver: bursts of random length, random gaps between them
    int burst_left = 0;
    int gap_left = 0;

    always @(posedge aclk) begin : request_driver
        resize_req_t req;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                s_valid  <= 1'b0;
            end else if (resize_requests.size() > 0) begin
                req = resize_requests.pop_front();
                s_valid       <= 1'b1;
                s_entry_count <= req.count;
                s_table_size  <= req.size;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(10, 1);
                    gap_left   <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(12, 1);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result sink: switches between always ready, a fixed stall pattern and
    // random stalls, and holds off once for a long stretch to back up the block
    rx_mode_t    rx_mode = RX_FULL;
    int          mode_timer = 0;
    int          hold_left = 0;
    bit          hold_done = 1'b0;
    int          taken_count = 0;
    logic [15:0] stall_pattern = 16'b1011_0010_1110_0101;

    always @(posedge aclk) begin : result_sink
        logic ready_next;
        ready_next = 1'b1;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready)
                taken_count <= taken_count + 1;
            stall_pattern <= {stall_pattern[14:0], stall_pattern[15]};
            if (hold_left > 0) begin
                hold_left  <= hold_left - 1;
                ready_next = 1'b0;
            end else if (!hold_done && taken_count >= HOLD_AFTER) begin
                hold_left  <= HOLD_CYCLES;
                hold_done  <= 1'b1;
                ready_next = 1'b0;
            end else begin
                if (mode_timer == 0) begin
                    rx_mode    <= rx_mode_t'($urandom_range(2, 0));
                    mode_timer <= 63;
                end else begin
                    mode_timer <= mode_timer - 1;
                end
                case (rx_mode)
                    RX_FULL:    ready_next = 1'b1;
                    RX_PATTERN: ready_next = stall_pattern[0];
                    default:    ready_next = ($urandom_range(3, 0) != 0);
                endcase
            end
            m_ready <= ready_next;
        end
    end

    // monitor: predict on each accepted request, compare each accepted result
    always @(posedge aclk) begin : resize_monitor
        resize_result_t want;
        if (aresetn) begin
            if (s_valid && s_ready)
                expected_resizes.push_back(predict_resize(s_entry_count, s_table_size));
            if (m_valid && m_ready) begin
                if (expected_resizes.size() == 0) begin
                    $display("%0t: unexpected result bucket_count=%0d status=%0d",
                             $time, m_bucket_count, m_status);
                    error_count++;
                end else begin
                    want = expected_resizes.pop_front();
                    if (m_bucket_count !== want.bucket_count) begin
                        $display("%0t: bucket_count mismatch expected %0d actual %0d",
                                 $time, want.bucket_count, m_bucket_count);
                        error_count++;
                    end
                    if (m_status !== want.status) begin
                        $display("%0t: status mismatch expected %0d actual %0d",
                                 $time, want.status, m_status);
                        error_count++;
                    end
                    results_checked++;
                end
            end
        end
    end

    // stimulus and end of run
    initial begin : stimulus
        logic [hrnp_pkg::COUNT_W-1:0] count;
        logic [hrnp_pkg::SIZE_W-1:0]  size;
        logic [63:0]                  keep_floor;
        int                           kind;

        // directed: boundaries of the load test, zero size, overfull and
        // not overfull, search past the ceiling, largest fields
        add_request(0, 1);
        add_request(0, 0);
        add_request(1, 0);
        add_request(1, 1);
        add_request(2, 1);
        add_request(3, 2);
        add_request(5, 3);
        add_request(100, 100);
        add_request(76, 100);
        add_request(75, 100);
        add_request(101, 100);
        add_request(1000, 1);
        add_request(4096, 5461);
        add_request(4096, 5462);
        add_request(31'h0010_0000, 32'h000F_FFFF);
        add_request(COUNT_MAX, 0);
        add_request(COUNT_MAX, 1);
        add_request(COUNT_MAX, 32'h7FFF_FFFF);
        add_request(COUNT_MAX, 32'd2863311529);
        add_request(COUNT_MAX, 32'd2863311530);
        add_request(COUNT_MAX, SIZE_ALL_ONES);
        add_request(0, SIZE_ALL_ONES);
        add_request(31'h5555_5555, 32'hAAAA_AAAA);
        add_request(31'h2AAA_AAAA, 32'h5555_5555);

        // random: mostly small counts so prime searches stay short, full-range
        // counts with sizes that keep the load test false, and overflow hits
        repeat (RANDOM_ITEMS) begin
            kind = $urandom_range(9, 0);
            if (kind <= 3) begin
                count = hrnp_pkg::COUNT_W'($urandom_range(4095, 0));
                size  = $urandom_range(2 * count + 2, 0);
            end else if (kind <= 5) begin
                count = hrnp_pkg::COUNT_W'($urandom_range(16383, 0));
                size  = $urandom_range(2 * count + 2, 0);
            end else if (kind <= 8) begin
                count      = hrnp_pkg::COUNT_W'($urandom());
                keep_floor = ({33'd0, count} * 4) / 3 + 1;
                size       = $urandom_range(SIZE_ALL_ONES, keep_floor[31:0]);
            end else begin
                count = COUNT_MAX;
                size  = $urandom_range(32'd2863311529, 0);
            end
            add_request(count, size);
        end

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        while (results_checked < request_total)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (expected_resizes.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, expected_resizes.size());
            error_count++;
        end
        if (error_count == 0) begin
            $display("** hash_resize_next_prime_top: PASSED **");
        end else begin
            $display("** hash_resize_next_prime_top: FAILED **");
        end
        $finish;
    end

    // watchdog, well above the slowest legal run
    initial begin : watchdog
        #40_000_000;
        $display("** hash_resize_next_prime_top: FAILED **");
        $finish;
    end

endmodule
